// ===== hdl/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types, widths and the CORDIC arctangent table for the compass.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int CORDIC_STEPS_DEF    = 16;

  localparam int Q_DEG   = 24;   // CORDIC angle accumulator fraction bits
  localparam int TAB_LEN = 24;
  localparam int DW      = 62;   // CORDIC x/y datapath width
  localparam int ZW      = 34;   // angle accumulator width
  localparam int IN_W    = 16;
  localparam int PITCH_W = 15;
  localparam int ANG_W   = 16;

  localparam logic signed [ZW-1:0] DEG90_Q  = ZW'(64'd90 << Q_DEG);
  localparam logic signed [ZW-1:0] DEG180_Q = ZW'(64'd180 << Q_DEG);

  // operand pairs handed from front to back
  typedef struct packed {
    logic signed [DW-1:0] pit_y;
    logic signed [DW-1:0] pit_x;
    logic signed [DW-1:0] rol_y;
    logic signed [DW-1:0] rol_x;
    logic signed [DW-1:0] yaw_y;
    logic signed [DW-1:0] yaw_x;
  } fb_item_t;

  // atan(2^-i) in degrees, Q24
  function automatic logic signed [ZW-1:0] atan_q(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:       v = ZW'(754974720);
      1:       v = ZW'(445687602);
      2:       v = ZW'(235489088);
      3:       v = ZW'(119537938);
      4:       v = ZW'(60000934);
      5:       v = ZW'(30029717);
      6:       v = ZW'(15018523);
      7:       v = ZW'(7509720);
      8:       v = ZW'(3754917);
      9:       v = ZW'(1877466);
      10:      v = ZW'(938734);
      11:      v = ZW'(469367);
      12:      v = ZW'(234684);
      13:      v = ZW'(117342);
      14:      v = ZW'(58671);
      15:      v = ZW'(29335);
      16:      v = ZW'(14668);
      17:      v = ZW'(7334);
      18:      v = ZW'(3667);
      19:      v = ZW'(1833);
      20:      v = ZW'(917);
      21:      v = ZW'(458);
      22:      v = ZW'(229);
      23:      v = ZW'(115);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/tilt_compensated_compass.sv =====
// ----------------------------------------------------------------------------
// tilt_compensated_compass
// Roll, pitch and tilt-compensated yaw from one accelerometer and one
// magnetometer sample, angles in 2^-ANGLE_FRAC_BITS degree.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  in       | start & !busy        | in_accel_x/y/z, in_mag_x/y/z (s16)
//  out      | out_valid, 1 cycle   | out_pitch_angle (s15), out_roll/yaw (s16)
//
//  One item per clock. Latency is fixed: 37 front stages (three product and
//  sum stages, a 33-stage square root, output register) and
//  min(CORDIC_STEPS,24) + 11 back stages, the CORDIC chain setting the back
//  part. rst_n is synchronous and empties all stages. The receiver cannot
//  stall; busy comes from the front/back queue filling and stays low since
//  the back drains it every cycle.
// ----------------------------------------------------------------------------
module tilt_compensated_compass #(
  parameter int ANGLE_FRAC_BITS = tcc_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = tcc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [15:0]  in_accel_x,
  input  logic signed [15:0]  in_accel_y,
  input  logic signed [15:0]  in_accel_z,
  input  logic signed [15:0]  in_mag_x,
  input  logic signed [15:0]  in_mag_y,
  input  logic signed [15:0]  in_mag_z,
  output logic                out_valid,
  output logic signed [14:0]  out_pitch_angle,
  output logic signed [15:0]  out_roll_angle,
  output logic signed [15:0]  out_yaw_angle
);
  import tcc_pkg::*;

  logic      accept_w;
  logic      fv_w;
  fb_item_t  fitem_w;
  logic      qv_w;
  fb_item_t  qitem_w;
  logic      qfull_w;

  assign accept_w = start && !busy;
  assign busy     = qfull_w;

  tcc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept_w),
    .in_accel_x (in_accel_x),
    .in_accel_y (in_accel_y),
    .in_accel_z (in_accel_z),
    .in_mag_x   (in_mag_x),
    .in_mag_y   (in_mag_y),
    .in_mag_z   (in_mag_z),
    .out_valid  (fv_w),
    .out_item   (fitem_w)
  );

  tcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fv_w),
    .push_item  (fitem_w),
    .full       (qfull_w),
    .pop_valid  (qv_w),
    .pop_item   (qitem_w)
  );

  tcc_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (qv_w),
    .in_item         (qitem_w),
    .out_valid       (out_valid),
    .out_pitch_angle (out_pitch_angle),
    .out_roll_angle  (out_roll_angle),
    .out_yaw_angle   (out_yaw_angle)
  );

endmodule

// ===== hdl/tcc_front.sv =====
// ----------------------------------------------------------------------------
// tcc_front
// Takes a sample, forms products and the two square roots, and builds the
// atan2 operand pairs for pitch, roll and yaw. Fixed latency, no stall.
// ----------------------------------------------------------------------------
module tcc_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic signed [15:0]         in_accel_x,
  input  logic signed [15:0]         in_accel_y,
  input  logic signed [15:0]         in_accel_z,
  input  logic signed [15:0]         in_mag_x,
  input  logic signed [15:0]         in_mag_y,
  input  logic signed [15:0]         in_mag_z,
  output logic                       out_valid,
  output tcc_pkg::fb_item_t          out_item
);
  import tcc_pkg::*;

  localparam int SQ_STEPS = 32;

  typedef struct packed {
    logic [63:0]          nr;
    logic [63:0]          rr;
    logic [63:0]          nm;
    logic [63:0]          rm;
    logic signed [15:0]   a0;
    logic signed [15:0]   a1;
    logic signed [15:0]   a2;
    logic signed [16:0]   sy;
    logic signed [16:0]   sx;
    logic signed [32:0]   t1;
    logic signed [50:0]   nxs;
    logic                 r2z;
  } sq_t;

  // stage A: products
  logic                 va_r;
  logic signed [15:0]   a0_a_r, a1_a_r, a2_a_r, mx_a_r, my_a_r, mz_a_r;
  logic signed [31:0]   sq0_a_r, sq1_a_r, sq2_a_r;
  logic signed [31:0]   mza1_a_r, mya2_a_r, mya1_a_r, mza2_a_r;

  // stage B: sums
  logic                 vb_r;
  logic signed [15:0]   a0_b_r, a1_b_r, a2_b_r, mx_b_r, my_b_r, mz_b_r;
  logic [31:0]          r2_b_r, m2_b_r;
  logic signed [32:0]   t1_b_r, t2_b_r;

  // stage C: wide products, degenerate-case operands
  logic                 vc_r;
  logic signed [15:0]   a0_c_r, a1_c_r, a2_c_r;
  logic signed [49:0]   mxr_c_r;
  logic signed [48:0]   a0t_c_r;
  logic signed [32:0]   t1_c_r;
  logic [31:0]          r2_c_r, m2_c_r;
  logic signed [16:0]   sy_c_r, sx_c_r;

  logic                 sv_r [SQ_STEPS+1];
  sq_t                  sq_r [SQ_STEPS+1];

  logic                 ve_r;
  fb_item_t             item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      ve_r <= sv_r[SQ_STEPS];
    end
  end

  // x and y of the accelerometer swap on entry
  always_ff @(posedge clk) begin
    a0_a_r   <= in_accel_y;
    a1_a_r   <= in_accel_x;
    a2_a_r   <= in_accel_z;
    mx_a_r   <= in_mag_x;
    my_a_r   <= in_mag_y;
    mz_a_r   <= in_mag_z;
    sq0_a_r  <= in_accel_y * in_accel_y;
    sq1_a_r  <= in_accel_x * in_accel_x;
    sq2_a_r  <= in_accel_z * in_accel_z;
    mza1_a_r <= in_mag_z * in_accel_x;
    mya2_a_r <= in_mag_y * in_accel_z;
    mya1_a_r <= in_mag_y * in_accel_x;
    mza2_a_r <= in_mag_z * in_accel_z;
  end

  always_ff @(posedge clk) begin
    a0_b_r <= a0_a_r;
    a1_b_r <= a1_a_r;
    a2_b_r <= a2_a_r;
    mx_b_r <= mx_a_r;
    my_b_r <= my_a_r;
    mz_b_r <= mz_a_r;
    r2_b_r <= 32'(sq1_a_r) + 32'(sq2_a_r);
    m2_b_r <= 32'(sq1_a_r) + 32'(sq2_a_r) + 32'(sq0_a_r);
    t1_b_r <= 33'(mza1_a_r) + 33'(mya2_a_r);
    t2_b_r <= 33'(mya1_a_r) - 33'(mza2_a_r);
  end

  always_ff @(posedge clk) begin
    a0_c_r  <= a0_b_r;
    a1_c_r  <= a1_b_r;
    a2_c_r  <= a2_b_r;
    mxr_c_r <= mx_b_r * signed'({1'b0, r2_b_r});
    a0t_c_r <= a0_b_r * t2_b_r;
    t1_c_r  <= t1_b_r;
    r2_c_r  <= r2_b_r;
    m2_c_r  <= m2_b_r;
    sy_c_r  <= -(17'(my_b_r));
    // accel x/z both zero: yaw = atan2(-my, sin p * mz), or mx when level
    if (a0_b_r > 16'sd0)
      sx_c_r <= -(17'(mz_b_r));
    else if (a0_b_r < 16'sd0)
      sx_c_r <= 17'(mz_b_r);
    else
      sx_c_r <= 17'(mx_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r[0] <= 1'b0;
    else        sv_r[0] <= vc_r;
  end

  always_ff @(posedge clk) begin
    sq_r[0].nr  <= {r2_c_r, 32'b0};
    sq_r[0].rr  <= '0;
    sq_r[0].nm  <= {16'b0, m2_c_r, 16'b0};
    sq_r[0].rm  <= '0;
    sq_r[0].a0  <= a0_c_r;
    sq_r[0].a1  <= a1_c_r;
    sq_r[0].a2  <= a2_c_r;
    sq_r[0].sy  <= sy_c_r;
    sq_r[0].sx  <= sx_c_r;
    sq_r[0].t1  <= t1_c_r;
    sq_r[0].nxs <= 51'(mxr_c_r) + 51'(a0t_c_r);
    sq_r[0].r2z <= (r2_c_r == '0);
  end

  // one result bit of both floor square roots per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    sq_t nxt_w;

    always_comb begin
      nxt_w = sq_r[k];
      if (sq_r[k].nr >= sq_r[k].rr + BITV) begin
        nxt_w.nr = sq_r[k].nr - (sq_r[k].rr + BITV);
        nxt_w.rr = (sq_r[k].rr >> 1) + BITV;
      end else begin
        nxt_w.rr = sq_r[k].rr >> 1;
      end
      if (sq_r[k].nm >= sq_r[k].rm + BITV) begin
        nxt_w.nm = sq_r[k].nm - (sq_r[k].rm + BITV);
        nxt_w.rm = (sq_r[k].rm >> 1) + BITV;
      end else begin
        nxt_w.rm = sq_r[k].rm >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) sv_r[k+1] <= 1'b0;
      else        sv_r[k+1] <= sv_r[k];
    end

    always_ff @(posedge clk) begin
      sq_r[k+1] <= nxt_w;
    end
  end

  sq_t                 fin_w;
  logic signed [58:0]  ny_w;
  fb_item_t            item_nxt;

  // both yaw operands carry the positive factor R*M
  always_comb begin
    fin_w          = sq_r[SQ_STEPS];
    ny_w           = fin_w.t1 * signed'({1'b0, fin_w.rm[24:0]});
    item_nxt.pit_y = DW'(fin_w.a0) <<< 16;
    item_nxt.pit_x = DW'(fin_w.rr[31:0]);
    item_nxt.rol_y = DW'(fin_w.a1);
    item_nxt.rol_x = DW'(fin_w.a2);
    if (fin_w.r2z) begin
      item_nxt.yaw_y = DW'(fin_w.sy);
      item_nxt.yaw_x = DW'(fin_w.sx);
    end else begin
      item_nxt.yaw_y = -(DW'(ny_w));
      item_nxt.yaw_x = DW'(fin_w.nxs) <<< 8;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = ve_r;
  assign out_item  = item_r;

endmodule

// ===== hdl/tcc_queue.sv =====
// ----------------------------------------------------------------------------
// tcc_queue
// Two-entry FIFO between front and back; the back drains it every cycle.
// ----------------------------------------------------------------------------
module tcc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcc_pkg::fb_item_t   push_item,
  output logic                full,
  output logic                pop_valid,
  output tcc_pkg::fb_item_t   pop_item
);
  import tcc_pkg::*;

  fb_item_t    mem_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop_w;
  logic        push_w;

  assign pop_w  = (cnt_r != 2'd0);
  assign push_w = push && (cnt_r != 2'd2);

  always_comb begin
    wp_nxt  = push_w ? ~wp_r : wp_r;
    rp_nxt  = pop_w ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push_w) - 2'(pop_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_w) mem_r[wp_r] <= push_item;
  end

  assign pop_valid = pop_w;
  assign pop_item  = mem_r[rp_r];
  assign full      = (cnt_r == 2'd2);

endmodule

// ===== hdl/tcc_cordic.sv =====
// ----------------------------------------------------------------------------
// tcc_cordic
// Pipelined vectoring CORDIC atan2 in degrees: quadrant fold, power-of-two
// normalization, one micro-rotation per stage, clamp and rounding.
// ----------------------------------------------------------------------------
module tcc_cordic #(
  parameter int ANGLE_FRAC_BITS = tcc_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = tcc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic signed [tcc_pkg::DW-1:0]        in_y,
  input  logic signed [tcc_pkg::DW-1:0]        in_x,
  output logic                                 out_valid,
  output logic signed [ANGLE_FRAC_BITS+8:0]    out_angle
);
  import tcc_pkg::*;

  localparam int OW     = ANGLE_FRAC_BITS + 9;
  localparam int NSTEP  = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;
  localparam int NNORM  = 7;
  localparam int LAST   = NNORM + NSTEP;
  localparam int RSH    = Q_DEG - ANGLE_FRAC_BITS;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [DW-1:0]        m;
    logic                 spec;
    logic signed [OW-1:0] sval;
  } cst_t;

  logic v_r  [LAST+1];
  cst_t st_r [LAST+1];
  cst_t pre_w;

  // exact answers for a zero operand; every operand is folded into the right half-plane
  always_comb begin
    pre_w      = '0;
    pre_w.x    = in_x;
    pre_w.y    = in_y;
    pre_w.z    = '0;
    pre_w.spec = 1'b0;
    pre_w.sval = '0;
    if (in_y == '0) begin
      pre_w.spec = 1'b1;
      pre_w.sval = (in_x < 0) ? OW'(180 << ANGLE_FRAC_BITS) : '0;
    end else if (in_x == '0) begin
      pre_w.spec = 1'b1;
      pre_w.sval = (in_y > 0) ? OW'(90 << ANGLE_FRAC_BITS)
                              : -(OW'(90 << ANGLE_FRAC_BITS));
    end
    if (in_x < 0) begin
      if (in_y > 0) begin
        pre_w.x = in_y;
        pre_w.y = -in_x;
        pre_w.z = DEG90_Q;
      end else begin
        pre_w.x = -in_y;
        pre_w.y = in_x;
        pre_w.z = -DEG90_Q;
      end
    end
    if (pre_w.y < 0)
      pre_w.m = (pre_w.x > -pre_w.y) ? pre_w.x : -pre_w.y;
    else
      pre_w.m = (pre_w.x > pre_w.y) ? pre_w.x : pre_w.y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else        v_r[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    st_r[0] <= pre_w;
  end

  // scale up until the larger magnitude reaches 2^40
  for (genvar j = 0; j < NNORM; j++) begin : g_norm
    localparam int SH  = (j < NNORM - 1) ? (32 >> j) : 1;
    localparam int THR = (j < NNORM - 1) ? (40 - SH) : 40;
    cst_t nxt_w;

    always_comb begin
      nxt_w = st_r[j];
      if ((st_r[j].m >> THR) == '0) begin
        nxt_w.x = st_r[j].x <<< SH;
        nxt_w.y = st_r[j].y <<< SH;
        nxt_w.m = st_r[j].m << SH;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[j+1] <= 1'b0;
      else        v_r[j+1] <= v_r[j];
    end

    always_ff @(posedge clk) begin
      st_r[j+1] <= nxt_w;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN = atan_q(i);
    cst_t cur_w;
    cst_t nxt_w;

    always_comb begin
      cur_w = st_r[NNORM+i];
      nxt_w = cur_w;
      if (cur_w.y > 0) begin
        nxt_w.x = cur_w.x + (cur_w.y >>> i);
        nxt_w.y = cur_w.y - (cur_w.x >>> i);
        nxt_w.z = cur_w.z + ATAN;
      end else begin
        nxt_w.x = cur_w.x - (cur_w.y >>> i);
        nxt_w.y = cur_w.y + (cur_w.x >>> i);
        nxt_w.z = cur_w.z - ATAN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[NNORM+i+1] <= 1'b0;
      else        v_r[NNORM+i+1] <= v_r[NNORM+i];
    end

    always_ff @(posedge clk) begin
      st_r[NNORM+i+1] <= nxt_w;
    end
  end

  logic signed [ZW-1:0] zc_w, mag_w, rnd_w;
  logic signed [OW-1:0] ang_w;
  logic                 ov_r;
  logic signed [OW-1:0] ang_r;

  // clamp to +-180, round half away from zero
  always_comb begin
    if (st_r[LAST].z > DEG180_Q)
      zc_w = DEG180_Q;
    else if (st_r[LAST].z < -DEG180_Q)
      zc_w = -DEG180_Q;
    else
      zc_w = st_r[LAST].z;
    mag_w = (zc_w < 0) ? -zc_w : zc_w;
    rnd_w = (mag_w + (ZW'(1) <<< (RSH - 1))) >>> RSH;
    if (st_r[LAST].spec)
      ang_w = st_r[LAST].sval;
    else if (zc_w < 0)
      ang_w = -(OW'(rnd_w));
    else
      ang_w = OW'(rnd_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= v_r[LAST];
  end

  always_ff @(posedge clk) begin
    ang_r <= ang_w;
  end

  assign out_valid = ov_r;
  assign out_angle = ang_r;

endmodule

// ===== hdl/tcc_back.sv =====
// ----------------------------------------------------------------------------
// tcc_back
// Three CORDIC pipelines side by side; signs and widths of the angles are
// fixed up in the output register.
// ----------------------------------------------------------------------------
module tcc_back #(
  parameter int ANGLE_FRAC_BITS = tcc_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = tcc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  tcc_pkg::fb_item_t   in_item,
  output logic                out_valid,
  output logic signed [14:0]  out_pitch_angle,
  output logic signed [15:0]  out_roll_angle,
  output logic signed [15:0]  out_yaw_angle
);
  import tcc_pkg::*;

  localparam int OW = ANGLE_FRAC_BITS + 9;

  logic                 pv_w;
  logic signed [OW-1:0] pit_w, rol_w, yaw_w;
  logic signed [31:0]   pn_w, rn_w, yw_w;
  logic                 ov_r;
  logic signed [PITCH_W-1:0] pit_r;
  logic signed [ANG_W-1:0]   rol_r, yaw_r;

  tcc_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_pit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_y      (in_item.pit_y),
    .in_x      (in_item.pit_x),
    .out_valid (pv_w),
    .out_angle (pit_w)
  );

  tcc_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_rol (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_y      (in_item.rol_y),
    .in_x      (in_item.rol_x),
    .out_valid (),
    .out_angle (rol_w)
  );

  tcc_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_y      (in_item.yaw_y),
    .in_x      (in_item.yaw_x),
    .out_valid (),
    .out_angle (yaw_w)
  );

  // pitch and roll are the negated arctangents
  always_comb begin
    pn_w = -(32'(pit_w));
    rn_w = -(32'(rol_w));
    yw_w = 32'(yaw_w);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= pv_w;
  end

  always_ff @(posedge clk) begin
    pit_r <= pn_w[PITCH_W-1:0];
    rol_r <= rn_w[ANG_W-1:0];
    yaw_r <= yw_w[ANG_W-1:0];
  end

  assign out_valid       = ov_r;
  assign out_pitch_angle = pit_r;
  assign out_roll_angle  = rol_r;
  assign out_yaw_angle   = yaw_r;

endmodule

// ===== hdl/tcc_checker.sv =====
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks on the compass: reset behavior, busy staying low and angle ranges.
// ----------------------------------------------------------------------------
module tcc_checker #(
  parameter int F = tcc_pkg::ANGLE_FRAC_BITS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic signed [14:0] out_pitch_angle,
  input logic signed [15:0] out_roll_angle,
  input logic signed [15:0] out_yaw_angle
);
  localparam int P_MAX = 90 << F;
  localparam int A_MAX = 180 << F;
  localparam bit FITS  = (F <= 7);

  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised although the back drains every cycle");

  a_pitch_rng: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && FITS |-> (out_pitch_angle >= -P_MAX) && (out_pitch_angle <= P_MAX))
    else $error("pitch out of range");

  a_roll_rng: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && FITS |-> (out_roll_angle >= -A_MAX) && (out_roll_angle <= A_MAX))
    else $error("roll out of range");

  a_yaw_rng: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid && FITS |-> (out_yaw_angle >= -A_MAX) && (out_yaw_angle <= A_MAX))
    else $error("yaw out of range");

endmodule

bind tilt_compensated_compass tcc_checker #(.F(ANGLE_FRAC_BITS)) u_tcc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_pitch_angle (out_pitch_angle),
  .out_roll_angle  (out_roll_angle),
  .out_yaw_angle   (out_yaw_angle)
);
